[hw/rtl/ifis_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ifis_pkg;

  localparam logic [31:0] FLT_MAX_BITS = 32'h7F7F_FFFF;
  localparam logic [31:0] QNAN_BITS    = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS     = 32'h7F80_0000;
  localparam logic [31:0] MAG_MASK     = 32'h7FFF_FFFF;
  localparam logic [31:0] SIGN_BIT     = 32'h8000_0000;

  function automatic logic is_nan(input logic [31:0] u);
    return (u & MAG_MASK) > INF_BITS;
  endfunction

  function automatic logic is_inf(input logic [31:0] u);
    return (u & MAG_MASK) == INF_BITS;
  endfunction

  // Ordered less-than: false when either side is NaN, and the two zeros are equal.
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | SIGN_BIT);
    kb = b[31] ? ~b : (b | SIGN_BIT);
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if ((a & MAG_MASK) == 32'd0 && (b & MAG_MASK) == 32'd0) begin
      return 1'b0;
    end
    return ka < kb;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/ifis_fma.sv]
`timescale 1ns / 1ps
`default_nettype none
module ifis_fma
  import ifis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] x,
  input  wire logic [31:0] y,
  input  wire logic [31:0] z,
  output logic             done,
  output logic [31:0]      result
);

  typedef enum logic [8:0] {
    F_IDLE  = 9'b000000001,
    F_MUL   = 9'b000000010,
    F_NORMA = 9'b000000100,
    F_NORMB = 9'b000001000,
    F_ALIGN = 9'b000010000,
    F_ADD   = 9'b000100000,
    F_NORMR = 9'b001000000,
    F_RND1  = 9'b010000000,
    F_RND2  = 9'b100000000
  } fstate_t;

  fstate_t state;

  logic [31:0] xr, yr, zr;
  logic [63:0] ma, mb, w;
  logic signed [11:0] ea, eb, we, e2;
  logic sa, sb, rs;
  logic [24:0] q;
  logic q_ovf;

  // Operand decode.
  logic [23:0] mx, my, mz;
  logic signed [11:0] ex, ey, ez;
  logic sx, sy, sz, sp;

  always_comb begin
    sx = xr[31];
    sy = yr[31];
    sz = zr[31];
    sp = sx ^ sy;
    mx = (xr[30:23] == 8'd0) ? {1'b0, xr[22:0]} : {1'b1, xr[22:0]};
    my = (yr[30:23] == 8'd0) ? {1'b0, yr[22:0]} : {1'b1, yr[22:0]};
    mz = (zr[30:23] == 8'd0) ? {1'b0, zr[22:0]} : {1'b1, zr[22:0]};
    ex = (xr[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, xr[30:23]}) - 12'sd150);
    ey = (yr[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, yr[30:23]}) - 12'sd150);
    ez = (zr[30:23] == 8'd0) ? -12'sd149 : ($signed({4'd0, zr[30:23]}) - 12'sd150);
  end

  logic [47:0] prod;
  assign prod = mx * my;

  // Shared normalizer step: coarse shifts never carry the leading one past the target.
  logic norm_ok;
  logic [63:0] w_step;
  logic signed [11:0] we_step;

  always_comb begin
    norm_ok = 1'b0;
    w_step  = w;
    we_step = we;
    if (state == F_NORMR) begin
      if (w[63:62] != 2'd0) begin
        norm_ok = 1'b1;
      end else if (w[63:46] == 18'd0) begin
        w_step = w << 16; we_step = we - 12'sd16;
      end else if (w[63:58] == 6'd0) begin
        w_step = w << 4;  we_step = we - 12'sd4;
      end else begin
        w_step = w << 1;  we_step = we - 12'sd1;
      end
    end else begin
      if (w[63:60] != 4'd0) begin
        norm_ok = 1'b1;
      end else if (w[63:44] == 20'd0) begin
        w_step = w << 16; we_step = we - 12'sd16;
      end else if (w[63:56] == 8'd0) begin
        w_step = w << 4;  we_step = we - 12'sd4;
      end else begin
        w_step = w << 1;  we_step = we - 12'sd1;
      end
    end
  end

  // Alignment of the smaller addend with a sticky bit.
  logic swap;
  logic [63:0] m_big, m_sml, m_aln;
  logic signed [11:0] e_big, e_sml, dexp;
  logic s_big, s_sml;

  always_comb begin
    swap  = (eb > ea) || (eb == ea && mb > ma);
    m_big = swap ? mb : ma;
    m_sml = swap ? ma : mb;
    e_big = swap ? eb : ea;
    e_sml = swap ? ea : eb;
    s_big = swap ? sb : sa;
    s_sml = swap ? sa : sb;
    dexp  = e_big - e_sml;
    if (dexp > 12'sd62) begin
      m_aln = 64'd1;
    end else if (dexp > 12'sd0) begin
      m_aln = (m_sml >> dexp[5:0])
            | {63'd0, (m_sml & ~(64'hFFFF_FFFF_FFFF_FFFF << dexp[5:0])) != 64'd0};
    end else begin
      m_aln = m_sml;
    end
  end

  logic [63:0] r_sum;
  assign r_sum = (sa == sb) ? (ma + mb) : (ma - mb);

  // Rounding to nearest even with the leading one at bit 62.
  logic signed [11:0] s_den, s_amt;
  logic [63:0] rem, half, q_shift;
  logic rnd_inc;

  always_comb begin
    s_den   = -12'sd149 - we;
    s_amt   = (s_den > 12'sd39) ? s_den : 12'sd39;
    q_shift = w >> s_amt[5:0];
    rem     = w & ~(64'hFFFF_FFFF_FFFF_FFFF << s_amt[5:0]);
    half    = 64'd1 << (s_amt[5:0] - 6'd1);
    rnd_inc = (rem > half) || (rem == half && q_shift[0]);
  end

  logic [24:0] q_fix;
  logic signed [11:0] e_fix, biased;

  always_comb begin
    q_fix = q;
    e_fix = e2;
    if (q == 25'h100_0000) begin
      q_fix = 25'h080_0000;
      e_fix = e2 + 12'sd1;
    end
    biased = e_fix + 12'sd150;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        F_IDLE: begin
          if (start) begin
            xr    <= x;
            yr    <= y;
            zr    <= z;
            state <= F_MUL;
          end
        end
        F_MUL: begin
          if (is_nan(xr) || is_nan(yr) || is_nan(zr)) begin
            result <= QNAN_BITS; done <= 1'b1; state <= F_IDLE;
          end else if (is_inf(xr) || is_inf(yr)) begin
            if ((xr & MAG_MASK) == 32'd0 || (yr & MAG_MASK) == 32'd0 ||
                (is_inf(zr) && sz != sp)) begin
              result <= QNAN_BITS;
            end else begin
              result <= {sp, INF_BITS[30:0]};
            end
            done <= 1'b1; state <= F_IDLE;
          end else if (is_inf(zr)) begin
            result <= zr; done <= 1'b1; state <= F_IDLE;
          end else if (prod == 48'd0) begin
            result <= (mz == 24'd0) ? {sp & sz, 31'd0} : zr;
            done   <= 1'b1; state <= F_IDLE;
          end else begin
            w  <= {16'd0, prod};
            we <= ex + ey;
            sa <= sp;
            rs <= sp;
            mb <= {40'd0, mz};
            eb <= ez;
            sb <= sz;
            state <= (mz == 24'd0) ? F_NORMR : F_NORMA;
          end
        end
        F_NORMA: begin
          if (norm_ok) begin
            ma <= w;  ea <= we;
            w  <= mb; we <= eb;
            state <= F_NORMB;
          end else begin
            w <= w_step; we <= we_step;
          end
        end
        F_NORMB: begin
          if (norm_ok) begin
            mb <= w; eb <= we;
            state <= F_ALIGN;
          end else begin
            w <= w_step; we <= we_step;
          end
        end
        F_ALIGN: begin
          ma <= m_big; ea <= e_big; sa <= s_big;
          mb <= m_aln; sb <= s_sml;
          state <= F_ADD;
        end
        F_ADD: begin
          if (r_sum == 64'd0) begin
            result <= 32'd0; done <= 1'b1; state <= F_IDLE;
          end else begin
            w <= r_sum; we <= ea; rs <= sa;
            state <= F_NORMR;
          end
        end
        F_NORMR: begin
          if (norm_ok) begin
            state <= F_RND1;
          end else begin
            w <= w_step; we <= we_step;
          end
        end
        F_RND1: begin
          q_ovf <= we > 12'sd65;
          e2    <= we + s_amt;
          if (s_amt >= 12'sd64) begin
            q <= 25'd0;
          end else begin
            q <= q_shift[24:0] + {24'd0, rnd_inc};
          end
          state <= F_RND2;
        end
        F_RND2: begin
          if (q_ovf) begin
            result <= {rs, INF_BITS[30:0]};
          end else if (q_fix[23]) begin
            if (biased >= 12'sd255) begin
              result <= {rs, INF_BITS[30:0]};
            end else begin
              result <= {rs, biased[7:0], q_fix[22:0]};
            end
          end else begin
            result <= {rs, 8'd0, q_fix[22:0]};
          end
          done  <= 1'b1;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[hw/rtl/inverse_fma_interval_search.sv]
`timescale 1ns / 1ps
`default_nettype none
// Finds the interval of finite floats x for which fma(x, b, c) falls inside the inclusive
// target [target_low, target_high]; a negative b is folded first by negating b, c and the
// target. One request is worked at a time, and in_stall stays high until it is done. Two
// binary searches over the float order run up to 64 evaluations of a single shared
// multi-cycle FMA unit. A search step is shortest when an operand is NaN or infinite or
// the product is zero, and longest when subnormal operands need long normalizing shifts.
// An empty answer shows x_low above x_high in float order. A finished result waits in an
// output register while the next request is accepted.
module inverse_fma_interval_search
  import ifis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] mul_operand,
  input  wire logic [31:0] add_operand,
  input  wire logic [31:0] target_low,
  input  wire logic [31:0] target_high,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      x_low,
  output logic [31:0]      x_high
);

  typedef enum logic [5:0] {
    T_IDLE  = 6'b000001,
    T_EVAL1 = 6'b000010,
    T_WAIT1 = 6'b000100,
    T_EVAL2 = 6'b001000,
    T_WAIT2 = 6'b010000,
    T_OUT   = 6'b100000
  } tstate_t;

  localparam logic signed [32:0] ORD_MAX = 33'sd2139095039;
  localparam logic signed [32:0] ORD_MIN = -33'sd2139095040;

  tstate_t state;
  logic [31:0] b, c, dlo, dhi;
  logic signed [32:0] lo, hi, mid, lower;

  logic signed [33:0] sum;
  logic signed [33:0] mid_dn, mid_up;
  assign sum    = {lo[32], lo} + {hi[32], hi};
  assign mid_dn = sum >>> 1;
  assign mid_up = (sum + 34'sd1) >>> 1;

  function automatic logic [31:0] from_order(input logic signed [32:0] v);
    return v[32] ? (v[31:0] ^ MAG_MASK) : v[31:0];
  endfunction

  logic fma_start, fma_done;
  logic [31:0] fma_x, fma_res;

  ifis_fma u_fma (
    .clk    (clk),
    .rst    (rst),
    .start  (fma_start),
    .x      (fma_x),
    .y      (b),
    .z      (c),
    .done   (fma_done),
    .result (fma_res)
  );

  assign in_stall  = (state != T_IDLE);
  assign fma_start = (state == T_EVAL1 && lo < hi) || (state == T_EVAL2 && lo < hi);
  assign fma_x     = (state == T_EVAL1) ? from_order(mid_dn[32:0]) : from_order(mid_up[32:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != T_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        T_IDLE: begin
          if (in_valid) begin
            if (f_lt(mul_operand, 32'd0)) begin
              b   <= mul_operand ^ SIGN_BIT;
              c   <= add_operand ^ SIGN_BIT;
              dlo <= target_high ^ SIGN_BIT;
              dhi <= target_low ^ SIGN_BIT;
            end else begin
              b   <= mul_operand;
              c   <= add_operand;
              dlo <= target_low;
              dhi <= target_high;
            end
            lo    <= ORD_MIN;
            hi    <= ORD_MAX;
            state <= T_EVAL1;
          end
        end
        T_EVAL1: begin
          if (lo < hi) begin
            mid   <= mid_dn[32:0];
            state <= T_WAIT1;
          end else begin
            lower <= lo;
            lo    <= lo - 33'sd1;
            hi    <= ORD_MAX;
            state <= T_EVAL2;
          end
        end
        T_WAIT1: begin
          if (fma_done) begin
            if (f_lt(fma_res, dlo)) begin
              lo <= mid + 33'sd1;
            end else begin
              hi <= mid;
            end
            state <= T_EVAL1;
          end
        end
        T_EVAL2: begin
          if (lo < hi) begin
            mid   <= mid_up[32:0];
            state <= T_WAIT2;
          end else begin
            state <= T_OUT;
          end
        end
        T_WAIT2: begin
          if (fma_done) begin
            if (f_lt(dhi, fma_res)) begin
              hi <= mid - 33'sd1;
            end else begin
              lo <= mid;
            end
            state <= T_EVAL2;
          end
        end
        T_OUT: begin
          // Hold the answer until the previous result has left the output register.
          if (!out_valid || !out_stall) begin
            x_low     <= from_order(lower);
            x_high    <= from_order(hi);
            out_valid <= 1'b1;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
